// File: hw/rtl/lcdw_pkg.sv
`timescale 1ns / 1ps

package lcdw_pkg;

  // Result kinds carried on the master-side tuser
  localparam logic [1:0] KIND_MARKER  = 2'd0;
  localparam logic [1:0] KIND_ADDRESS = 2'd1;
  localparam logic [1:0] KIND_NIBBLE  = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // Write mode phases
  localparam logic [1:0] WPH_NONE    = 2'd0;
  localparam logic [1:0] WPH_ADDRESS = 2'd1;
  localparam logic [1:0] WPH_DATA    = 2'd2;

  // Command mode phases
  localparam logic [1:0] CPH_NONE  = 2'd0;
  localparam logic [1:0] CPH_FIVE  = 2'd1;
  localparam logic [1:0] CPH_FOUR  = 2'd2;

  // Mode codes, three bits MSB first
  localparam logic [5:0] MODE_WRITE   = 6'h05;
  localparam logic [5:0] MODE_COMMAND = 6'h04;

  // Group lengths in bits
  localparam logic [2:0] LEN_MODE    = 3'd3;
  localparam logic [2:0] LEN_ADDRESS = 3'd6;
  localparam logic [2:0] LEN_NIBBLE  = 3'd4;
  localparam logic [2:0] LEN_CMD_A   = 3'd5;
  localparam logic [2:0] LEN_CMD_B   = 3'd4;

  localparam logic [15:0] IDLE_THRESHOLD_RESET = 16'd450;

  // One decoded event
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [5:0] value;
  } event_t;

endpackage

// File: hw/rtl/lcdw_decode.sv
`timescale 1ns / 1ps

module lcdw_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               cs_n,
  input  logic               wr_n,
  input  logic               data_in,
  output lcdw_pkg::event_t   evt
);

  logic       strobe_prev, strobe_prev_next;
  logic [2:0] bit_count, bit_count_next;
  logic [5:0] shift_value, shift_value_next;
  logic [1:0] write_phase, write_phase_next;
  logic [1:0] command_phase, command_phase_next;

  logic [5:0] sv_in;
  logic [2:0] bc_in;

  assign sv_in = shift_value | {5'd0, data_in};
  assign bc_in = bit_count + 3'd1;

  // Shift in on rising strobe and close groups at their length
  always_comb begin
    strobe_prev_next   = strobe_prev;
    bit_count_next     = bit_count;
    shift_value_next   = shift_value;
    write_phase_next   = write_phase;
    command_phase_next = command_phase;
    evt                = '0;
    if (!cs_n) begin
      strobe_prev_next = wr_n;
      if (wr_n && !strobe_prev) begin
        bit_count_next   = 3'd0;
        shift_value_next = 6'd0;
        if (write_phase == lcdw_pkg::WPH_DATA && bc_in == lcdw_pkg::LEN_NIBBLE) begin
          evt.valid = 1'b1;
          evt.kind  = lcdw_pkg::KIND_NIBBLE;
          evt.value = sv_in;
        end else if (write_phase == lcdw_pkg::WPH_ADDRESS &&
                     bc_in == lcdw_pkg::LEN_ADDRESS) begin
          write_phase_next = lcdw_pkg::WPH_DATA;
          evt.valid = 1'b1;
          evt.kind  = lcdw_pkg::KIND_ADDRESS;
          evt.value = sv_in;
        end else if (write_phase == lcdw_pkg::WPH_NONE &&
                     command_phase == lcdw_pkg::CPH_NONE &&
                     bc_in == lcdw_pkg::LEN_MODE) begin
          if (sv_in == lcdw_pkg::MODE_WRITE) begin
            write_phase_next = lcdw_pkg::WPH_ADDRESS;
            evt.valid = 1'b1;
            evt.kind  = lcdw_pkg::KIND_MARKER;
          end else if (sv_in == lcdw_pkg::MODE_COMMAND) begin
            command_phase_next = lcdw_pkg::CPH_FIVE;
          end
        end else if (command_phase == lcdw_pkg::CPH_FIVE &&
                     bc_in == lcdw_pkg::LEN_CMD_A) begin
          command_phase_next = lcdw_pkg::CPH_FOUR;
        end else if (command_phase == lcdw_pkg::CPH_FOUR &&
                     bc_in == lcdw_pkg::LEN_CMD_B) begin
          // drop the command group
        end else begin
          bit_count_next   = bc_in;
          shift_value_next = {sv_in[4:0], 1'b0};
        end
      end
    end else begin
      // deselect clears the decoder
      strobe_prev_next   = 1'b1;
      bit_count_next     = 3'd0;
      shift_value_next   = 6'd0;
      write_phase_next   = lcdw_pkg::WPH_NONE;
      command_phase_next = lcdw_pkg::CPH_NONE;
    end
  end

  // Advance decoder state once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_prev   <= 1'b1;
      bit_count     <= 3'd0;
      shift_value   <= 6'd0;
      write_phase   <= lcdw_pkg::WPH_NONE;
      command_phase <= lcdw_pkg::CPH_NONE;
    end else if (en) begin
      strobe_prev   <= strobe_prev_next;
      bit_count     <= bit_count_next;
      shift_value   <= shift_value_next;
      write_phase   <= write_phase_next;
      command_phase <= command_phase_next;
    end
  end

endmodule

// File: hw/rtl/lcdw_idle.sv
`timescale 1ns / 1ps

module lcdw_idle (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        cs_n,
  input  logic [15:0] threshold,
  output logic        fire
);

  logic [15:0] idle_count, idle_count_next;
  logic [16:0] count_inc;

  assign count_inc = {1'b0, idle_count} + 17'd1;

  // Count deselected words, saturate at the threshold, fire on reaching it
  always_comb begin
    fire = 1'b0;
    if (!cs_n) begin
      idle_count_next = 16'd0;
    end else if (count_inc == {1'b0, threshold}) begin
      idle_count_next = count_inc[15:0];
      fire            = 1'b1;
    end else if (count_inc > {1'b0, threshold}) begin
      idle_count_next = threshold;
    end else begin
      idle_count_next = count_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= 16'd0;
    end else if (en) begin
      idle_count <= idle_count_next;
    end
  end

endmodule

// File: hw/rtl/lcd_three_wire_write_decoder.sv
`timescale 1ns / 1ps

// Snooper for a three-wire LCD write bus. Each slave-side word is one sample
// of the chip select, write strobe and data pins; samples must arrive without
// gaps for strobe edges to be seen. The block takes one word per clock when
// not stalled and holds it in the input register; its result goes from there
// through the decode logic into the output register. Back pressure on the
// master side stalls both registers together; a word that yields no result
// still passes the output register slot. Results are write mode markers,
// addresses, data nibbles and one end-of-burst event after cfg_data
// deselected samples (reset 450, zero disables it).

module lcd_three_wire_write_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] cs_n, [1] wr_n, [2] data_in, [7:3] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] value, [7:6] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] idle_threshold;

  logic        in_valid;
  logic        in_cs_n;
  logic        in_wr_n;
  logic        in_data;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [5:0]  out_value;

  logic        advance;
  logic        proc;
  logic        idle_fire;

  lcdw_pkg::event_t dec_evt;
  lcdw_pkg::event_t res;

  assign advance       = !out_valid || m_axis_tready;
  assign proc          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_threshold <= lcdw_pkg::IDLE_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      idle_threshold <= cfg_data;
    end
  end

  // Capture the pin sample word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cs_n <= s_axis_tdata[0];
      in_wr_n <= s_axis_tdata[1];
      in_data <= s_axis_tdata[2];
    end
  end

  lcdw_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .en      (proc),
    .cs_n    (in_cs_n),
    .wr_n    (in_wr_n),
    .data_in (in_data),
    .evt     (dec_evt)
  );

  lcdw_idle u_idle (
    .clk       (clk),
    .rst       (rst),
    .en        (proc),
    .cs_n      (in_cs_n),
    .threshold (idle_threshold),
    .fire      (idle_fire)
  );

  // Merge decoder and idle events; they never coincide
  always_comb begin
    res = dec_evt;
    if (idle_fire) begin
      res.valid = 1'b1;
      res.kind  = lcdw_pkg::KIND_END;
      res.value = 6'd0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= proc && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind  <= res.kind;
      out_value <= res.value;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_value};
  assign m_axis_tuser  = out_kind;

endmodule

// File: tb/lcd_three_wire_write_decoder_test.sv
`timescale 1ns / 1ps

module lcd_three_wire_write_decoder_test;

  // Cap well above what a correct run needs; leave wide margin
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] value;
  } lcd_event_t;

  typedef struct packed {
    logic       cs_n;
    logic       wr_n;
    logic       data_in;
    logic       typed;
    logic [1:0] kind;
    logic [5:0] value;
  } stim_row_t;

  localparam lcd_event_t NO_EVENT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h01;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  // Decoder state as seen by the predictor
  logic       strobe_last;
  logic [2:0] bits_taken;
  logic [5:0] shift_reg;
  logic [1:0] write_stage;
  logic [1:0] command_stage;
  int         idle_run;
  int         idle_limit;

  lcd_event_t pending_events[$];

  int samples_sent;
  int settings_used;
  int mismatches;
  int cycle_count;
  int kind_count [4];
  int burst_left;
  bit steady;
  int stall_left;
  int stall_mode;

  // Directed walk: reselect, end of burst, write mode, address 63, nibble 0, deselect
  stim_row_t bench_rows [30] = '{
    '{1'b0, 1'b1, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b1, 1'b0, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b1, 1'b1, 1'b0, 1'b1, lcdw_pkg::KIND_END,     6'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b1, 1'b1, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b1, 1'b1, lcdw_pkg::KIND_ADDRESS, 6'd63},
    '{1'b0, 1'b0, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b0, 1'b1, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0},
    '{1'b0, 1'b1, 1'b0, 1'b1, lcdw_pkg::KIND_NIBBLE,  6'd0},
    '{1'b1, 1'b0, 1'b0, 1'b0, lcdw_pkg::KIND_MARKER,  6'd0}
  };

  lcd_three_wire_write_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no progress, %0d results still outstanding", $time,
               pending_events.size());
      $display("lcd_three_wire_write_decoder: mismatch");
      $finish;
    end
  end

  // Stall the receiver: free-running, light and heavy stretches
  always @(negedge clk) begin
    if (stall_left <= 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 9) < 3);
      end
    endcase
  end

  // Compare each delivered word with the oldest predicted event
  always @(posedge clk) begin : check_results
    lcd_event_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got kind %0d value %0d", $time,
                 m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_events.pop_front();
        kind_count[want.kind]++;
        if (m_axis_tuser !== want.kind) begin
          mismatches++;
          $display("%0t: kind expected %0d, got %0d", $time, want.kind, m_axis_tuser);
        end
        if (m_axis_tdata !== {2'b00, want.value}) begin
          mismatches++;
          $display("%0t: value expected %0d, got %0d", $time, want.value, m_axis_tdata);
        end
      end
    end
  end

  task automatic reset_decoder_state();
    strobe_last   = 1'b1;
    bits_taken    = '0;
    shift_reg     = '0;
    write_stage   = lcdw_pkg::WPH_NONE;
    command_stage = lcdw_pkg::CPH_NONE;
    idle_run      = 0;
    idle_limit    = int'(lcdw_pkg::IDLE_THRESHOLD_RESET);
  endtask

  // Advance the decoder by one pin sample; report the event it yields, if any
  task automatic decode_pin_sample(input logic cs_n, input logic wr_n, input logic data_in,
                                   output logic hit, output lcd_event_t ev);
    int next_idle;
    hit = 1'b0;
    ev  = NO_EVENT;
    if (!cs_n) begin
      if (wr_n && !strobe_last) begin
        shift_reg  = shift_reg | {5'd0, data_in};
        bits_taken = bits_taken + 3'd1;
        if (write_stage == lcdw_pkg::WPH_DATA && bits_taken == lcdw_pkg::LEN_NIBBLE) begin
          hit = 1'b1;
          ev  = '{lcdw_pkg::KIND_NIBBLE, shift_reg};
          bits_taken = '0;
          shift_reg  = '0;
        end else if (write_stage == lcdw_pkg::WPH_ADDRESS &&
                     bits_taken == lcdw_pkg::LEN_ADDRESS) begin
          write_stage = lcdw_pkg::WPH_DATA;
          hit = 1'b1;
          ev  = '{lcdw_pkg::KIND_ADDRESS, shift_reg};
          bits_taken = '0;
          shift_reg  = '0;
        end else if (write_stage == lcdw_pkg::WPH_NONE &&
                     command_stage == lcdw_pkg::CPH_NONE &&
                     bits_taken == lcdw_pkg::LEN_MODE) begin
          if (shift_reg == lcdw_pkg::MODE_WRITE) begin
            write_stage = lcdw_pkg::WPH_ADDRESS;
            hit = 1'b1;
            ev  = '{lcdw_pkg::KIND_MARKER, 6'd0};
          end else if (shift_reg == lcdw_pkg::MODE_COMMAND) begin
            command_stage = lcdw_pkg::CPH_FIVE;
          end
          bits_taken = '0;
          shift_reg  = '0;
        end else if (command_stage == lcdw_pkg::CPH_FIVE &&
                     bits_taken == lcdw_pkg::LEN_CMD_A) begin
          command_stage = lcdw_pkg::CPH_FOUR;
          bits_taken = '0;
          shift_reg  = '0;
        end else if (command_stage == lcdw_pkg::CPH_FOUR &&
                     bits_taken == lcdw_pkg::LEN_CMD_B) begin
          bits_taken = '0;
          shift_reg  = '0;
        end else begin
          shift_reg = shift_reg << 1;
        end
      end
      strobe_last = wr_n;
      idle_run    = 0;
    end else begin
      // Deselect clears the decoder; the idle count saturates at the threshold
      next_idle     = idle_run + 1;
      strobe_last   = 1'b1;
      bits_taken    = '0;
      shift_reg     = '0;
      write_stage   = lcdw_pkg::WPH_NONE;
      command_stage = lcdw_pkg::CPH_NONE;
      if (next_idle == idle_limit) begin
        idle_run = next_idle;
        hit = 1'b1;
        ev  = '{lcdw_pkg::KIND_END, 6'd0};
      end else if (next_idle > idle_limit) begin
        idle_run = idle_limit;
      end else begin
        idle_run = next_idle;
      end
    end
  endtask

  // Send one pin sample in bursts; entered and left at a falling edge
  task automatic push_sample(input logic cs_n, input logic wr_n, input logic data_in,
                             input logic typed, input lcd_event_t typed_event);
    int gap;
    logic hit;
    lcd_event_t ev;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tdata  <= {5'd0, data_in, wr_n, cs_n};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_pin_sample(cs_n, wr_n, data_in, hit, ev);
    if (typed) begin
      pending_events.push_back(typed_event);
    end else if (hit) begin
      pending_events.push_back(ev);
    end
    burst_left--;
    samples_sent++;
    @(negedge clk);
  endtask

  // One strobe cycle: low samples with loose data, then the rising edge with the bit
  task automatic send_bit(input logic bit_value);
    int lows;
    int highs;
    lows  = ($urandom_range(0, 3) == 0) ? 2 : 1;
    highs = ($urandom_range(0, 3) == 0) ? 2 : 1;
    repeat (lows) push_sample(1'b0, 1'b0, $urandom_range(0, 1) != 0, 1'b0, NO_EVENT);
    repeat (highs) push_sample(1'b0, 1'b1, bit_value, 1'b0, NO_EVENT);
  endtask

  task automatic send_group(input logic [5:0] group, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) send_bit(group[i]);
  endtask

  task automatic deselect_run(input int len);
    repeat (len) begin
      push_sample(1'b1, $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0, 1'b0, NO_EVENT);
    end
  endtask

  // Mostly short gaps between frames, some that land around the threshold
  function automatic int pick_idle_length();
    int r;
    int lo;
    r  = $urandom_range(0, 99);
    lo = (idle_limit > 2) ? idle_limit - 2 : 1;
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) begin
      if (idle_limit <= 64) return $urandom_range(lo, idle_limit + 3);
      return $urandom_range(1, 30);
    end
    if (r < 93 && idle_limit <= 600) return $urandom_range(lo, idle_limit + 3);
    return $urandom_range(1, 40);
  endfunction

  // Mostly well-formed write and command frames, plus bad modes, noise and idle
  task automatic random_traffic(input int quota);
    int start;
    int pick;
    start = samples_sent;
    deselect_run(pick_idle_length());
    while (samples_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        deselect_run($urandom_range(1, 3));
        send_group(lcdw_pkg::MODE_WRITE, 3);
        if ($urandom_range(0, 7) == 0) begin
          send_group(6'($urandom_range(0, 63)), $urandom_range(1, 5));
        end else begin
          send_group(6'($urandom_range(0, 63)), 6);
          repeat ($urandom_range(0, 6)) send_group(6'($urandom_range(0, 15)), 4);
          if ($urandom_range(0, 9) == 0) begin
            send_group(6'($urandom_range(0, 7)), $urandom_range(1, 3));
          end
        end
      end else if (pick < 60) begin
        deselect_run($urandom_range(1, 3));
        send_group(lcdw_pkg::MODE_COMMAND, 3);
        send_group(6'($urandom_range(0, 31)), 5);
        repeat ($urandom_range(0, 3)) send_group(6'($urandom_range(0, 15)), 4);
      end else if (pick < 70) begin
        deselect_run($urandom_range(1, 2));
        send_group(6'($urandom_range(0, 7)), 3);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 12)) begin
          push_sample($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                      $urandom_range(0, 1) != 0, 1'b0, NO_EVENT);
        end
      end else begin
        deselect_run(pick_idle_length());
      end
    end
    deselect_run(pick_idle_length());
  endtask

  // Wait for every predicted word, then let the pipeline empty
  task automatic settle_block();
    int quiet;
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      if (m_axis_tready) quiet++;
    end
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] limit);
    cfg_data  <= limit;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    idle_limit = int'(limit);
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    reset_decoder_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset threshold
    random_traffic(300);

    // Directed walk, then random with a tiny threshold
    settle_block();
    write_threshold(16'd2);
    foreach (bench_rows[i]) begin
      push_sample(bench_rows[i].cs_n, bench_rows[i].wr_n, bench_rows[i].data_in,
                  bench_rows[i].typed, {bench_rows[i].kind, bench_rows[i].value});
    end
    random_traffic(300);

    settle_block();
    write_threshold(16'd1);
    random_traffic(250);

    // Zero threshold disables the end event
    settle_block();
    write_threshold(16'd0);
    random_traffic(250);

    // Largest threshold, sender without gaps
    settle_block();
    write_threshold(16'hFFFF);
    steady = 1'b1;
    random_traffic(150);
    steady = 1'b0;

    // Lower the threshold below a running idle count: clamp, no event
    settle_block();
    write_threshold(16'd40);
    random_traffic(300);
    deselect_run(35);
    settle_block();
    write_threshold(16'd8);
    random_traffic(150);

    settle_block();
    write_threshold(lcdw_pkg::IDLE_THRESHOLD_RESET);
    random_traffic(250);

    settle_block();
    $display("covered %0d pin samples under %0d threshold settings (0, 1 and 65535 among them)",
             samples_sent, settings_used + 1);
    $display("words checked: %0d markers, %0d addresses, %0d nibbles, %0d end events",
             kind_count[lcdw_pkg::KIND_MARKER], kind_count[lcdw_pkg::KIND_ADDRESS],
             kind_count[lcdw_pkg::KIND_NIBBLE], kind_count[lcdw_pkg::KIND_END]);
    if (mismatches == 0) begin
      $display("lcd_three_wire_write_decoder: match");
    end else begin
      $display("lcd_three_wire_write_decoder: mismatch");
    end
    $finish;
  end

endmodule
